>>> hdl/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg: shared types and constants of the GPIO register block
// Register map offsets, mode codes and the access and result records.
// ----------------------------------------------------------------------------
package gpr_pkg;

    localparam int PIN_COUNT     = 32;
    localparam int PINS_PER_WORD = 10;
    localparam int FSEL_WORDS    = 4;
    localparam int DATA_W        = 32;
    localparam int OFFSET_W      = 10;

    localparam logic [DATA_W-1:0] PIN_MASK =
        DATA_W'((64'd1 << PIN_COUNT) - 64'd1);

    // Register map (word offsets)
    localparam logic [OFFSET_W-1:0] OFF_FSEL_FIRST = 10'd0;
    localparam logic [OFFSET_W-1:0] OFF_FSEL_LAST  = 10'(FSEL_WORDS - 1);
    localparam logic [OFFSET_W-1:0] OFF_SET        = 10'd7;
    localparam logic [OFFSET_W-1:0] OFF_CLR        = 10'd10;
    localparam logic [OFFSET_W-1:0] OFF_LEV        = 10'd13;
    localparam logic [OFFSET_W-1:0] OFF_PUD        = 10'd37;
    localparam logic [OFFSET_W-1:0] OFF_PUDCLK     = 10'd38;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef logic [2:0] t_fn;
    typedef logic [1:0] t_pull;

    localparam t_fn   FN_OUTPUT = 3'd1;
    localparam t_pull PULL_DOWN = 2'd1;
    localparam t_pull PULL_UP   = 2'd2;
    localparam t_pull PULL_KEEP = 2'd3;

    typedef struct packed {
        logic                op;
        logic [OFFSET_W-1:0] word_offset;
        logic [DATA_W-1:0]   write_data;
        logic [DATA_W-1:0]   pin_inputs;
    } t_access;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [DATA_W-1:0] drive_level;
        logic [DATA_W-1:0] drive_enable;
        logic [DATA_W-1:0] pull_up_on;
        logic [DATA_W-1:0] pull_down_on;
    } t_result;

endpackage

>>> hdl/gpr_regs.sv
// ----------------------------------------------------------------------------
// gpr_regs: GPIO register state and access decode
// Holds function, latch, pull state; one registered access a cycle on i_fire.
// ----------------------------------------------------------------------------
module gpr_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  gpr_pkg::t_access i_acc,
    output gpr_pkg::t_result o_result
);

    gpr_pkg::t_fn                  r_fn   [gpr_pkg::PIN_COUNT];
    gpr_pkg::t_fn                  n_fn   [gpr_pkg::PIN_COUNT];
    gpr_pkg::t_pull                r_pull [gpr_pkg::PIN_COUNT];
    gpr_pkg::t_pull                n_pull [gpr_pkg::PIN_COUNT];
    logic [gpr_pkg::DATA_W-1:0]    r_latch, n_latch;
    logic [gpr_pkg::DATA_W-1:0]    r_clk,   n_clk;
    gpr_pkg::t_pull                r_mode,  n_mode;

    logic [gpr_pkg::DATA_W-1:0]    fsel_rd [gpr_pkg::FSEL_WORDS];
    logic [gpr_pkg::DATA_W-1:0]    outs_now;
    logic [gpr_pkg::DATA_W-1:0]    rd;

    // Function-select words as read back
    always_comb begin
        for (int w = 0; w < gpr_pkg::FSEL_WORDS; w++) begin
            fsel_rd[w] = '0;
            for (int k = 0; k < gpr_pkg::PINS_PER_WORD; k++) begin
                if (w * gpr_pkg::PINS_PER_WORD + k < gpr_pkg::PIN_COUNT) begin
                    fsel_rd[w][3*k +: 3] = r_fn[w * gpr_pkg::PINS_PER_WORD + k];
                end
            end
        end
    end

    always_comb begin
        outs_now = '0;
        for (int p = 0; p < gpr_pkg::PIN_COUNT; p++) begin
            outs_now[p] = (r_fn[p] == gpr_pkg::FN_OUTPUT);
        end
    end

    // Next state and read data
    always_comb begin
        n_fn    = r_fn;
        n_pull  = r_pull;
        n_latch = r_latch;
        n_clk   = r_clk;
        n_mode  = r_mode;
        rd      = '0;
        if (i_acc.op == gpr_pkg::OP_WRITE) begin
            case (i_acc.word_offset) inside
                [gpr_pkg::OFF_FSEL_FIRST:gpr_pkg::OFF_FSEL_LAST]: begin
                    for (int w = 0; w < gpr_pkg::FSEL_WORDS; w++) begin
                        for (int k = 0; k < gpr_pkg::PINS_PER_WORD; k++) begin
                            if ((i_acc.word_offset[1:0] == 2'(w)) &&
                                (w * gpr_pkg::PINS_PER_WORD + k < gpr_pkg::PIN_COUNT)) begin
                                n_fn[w * gpr_pkg::PINS_PER_WORD + k] =
                                    i_acc.write_data[3*k +: 3];
                            end
                        end
                    end
                end
                gpr_pkg::OFF_SET: begin
                    n_latch = (r_latch | i_acc.write_data) & gpr_pkg::PIN_MASK;
                end
                gpr_pkg::OFF_CLR: begin
                    n_latch = r_latch & ~i_acc.write_data & gpr_pkg::PIN_MASK;
                end
                gpr_pkg::OFF_PUD: begin
                    n_mode = i_acc.write_data[1:0];
                end
                gpr_pkg::OFF_PUDCLK: begin
                    n_clk = i_acc.write_data & gpr_pkg::PIN_MASK;
                    if (r_mode != gpr_pkg::PULL_KEEP) begin
                        for (int p = 0; p < gpr_pkg::PIN_COUNT; p++) begin
                            if (i_acc.write_data[p]) begin
                                n_pull[p] = r_mode;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end else begin
            case (i_acc.word_offset) inside
                [gpr_pkg::OFF_FSEL_FIRST:gpr_pkg::OFF_FSEL_LAST]: begin
                    rd = fsel_rd[i_acc.word_offset[1:0]];
                end
                gpr_pkg::OFF_LEV: begin
                    rd = ((r_latch & outs_now) | (i_acc.pin_inputs & ~outs_now))
                         & gpr_pkg::PIN_MASK;
                end
                gpr_pkg::OFF_PUD: begin
                    rd = {{(gpr_pkg::DATA_W-2){1'b0}}, r_mode};
                end
                gpr_pkg::OFF_PUDCLK: begin
                    rd = r_clk;
                end
                default: begin
                    rd = '0;
                end
            endcase
        end
    end

    // Result reflects the state after the access
    always_comb begin
        o_result              = '0;
        o_result.read_data    = rd;
        o_result.drive_level  = n_latch & gpr_pkg::PIN_MASK;
        for (int p = 0; p < gpr_pkg::PIN_COUNT; p++) begin
            o_result.drive_enable[p] = (n_fn[p] == gpr_pkg::FN_OUTPUT);
            o_result.pull_up_on[p]   = (n_pull[p] == gpr_pkg::PULL_UP);
            o_result.pull_down_on[p] = (n_pull[p] == gpr_pkg::PULL_DOWN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < gpr_pkg::PIN_COUNT; p++) begin
                r_fn[p]   <= '0;
                r_pull[p] <= '0;
            end
            r_latch <= '0;
            r_clk   <= '0;
            r_mode  <= '0;
        end else if (i_fire) begin
            r_fn    <= n_fn;
            r_pull  <= n_pull;
            r_latch <= n_latch;
            r_clk   <= n_clk;
            r_mode  <= n_mode;
        end
    end

endmodule

>>> hdl/gpr_out.sv
// ----------------------------------------------------------------------------
// gpr_out: result register with skid stage
// Holds up to two results so the access stage keeps moving under a stall.
// ----------------------------------------------------------------------------
module gpr_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  gpr_pkg::t_result i_result,
    output logic             o_can_take,
    output logic             o_valid,
    input  logic             i_ready,
    output gpr_pkg::t_result o_result
);

    logic             r_main_vld;
    logic             r_skid_vld;
    gpr_pkg::t_result r_main;
    gpr_pkg::t_result r_skid;
    logic             take;

    assign take       = r_main_vld && i_ready;
    assign o_can_take = !r_skid_vld;
    assign o_valid    = r_main_vld;
    assign o_result   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (take) begin
            if (r_skid_vld) begin
                r_main_vld <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_main_vld <= i_load;
            end
        end else if (i_load) begin
            if (!r_main_vld) begin
                r_main_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    // Payload: refill from skid first, else from the access stage
    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skid_vld) begin
                r_main <= r_skid;
            end else if (i_load) begin
                r_main <= i_result;
            end
        end else if (i_load) begin
            if (!r_main_vld) begin
                r_main <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

endmodule

>>> hdl/gpio_register_block.sv
// ----------------------------------------------------------------------------
// gpio_register_block: register-mapped GPIO bank
// Function select, set/clear latch, level read and pull control for the pins.
// ----------------------------------------------------------------------------
// Usage
//   Access channel (i_valid / o_ready): one bus access per item - op, word
//   offset, write data and the sampled pin levels. Result channel
//   (o_valid / i_ready): one item per access with read data and the drive,
//   drive-enable and pull vectors as they stand after that access.
//   Path: an accepted access waits in the input register, is decoded and
//   applied when the result side has room, and its result is loaded into
//   the result register, which drives o_valid.
//   Throughput: one access per cycle while the result side has room, set
//   by the combinational decode and update path into the result register.
//   Stall: while i_ready is low the result register holds and a skid entry
//   absorbs one more result; o_ready drops only once both are full and an
//   access is waiting in the input register.
//   Reset (synchronous, active low): every pin becomes an input with no
//   pull, the latch, pull mode and pull clock clear, and all queued items
//   are dropped.
// ----------------------------------------------------------------------------
module gpio_register_block (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [9:0]  i_word_offset,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_pin_inputs,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_data,
    output logic [31:0] o_drive_level,
    output logic [31:0] o_drive_enable,
    output logic [31:0] o_pull_up_on,
    output logic [31:0] o_pull_down_on
);

    logic             r_in_vld;
    gpr_pkg::t_access r_acc;
    logic             advance;
    logic             out_can_take;
    gpr_pkg::t_result stage_result;
    gpr_pkg::t_result out_result;

    // Advance the held access whenever the output side has room
    assign advance = r_in_vld && out_can_take;
    assign o_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    // Hold the access payload until it advances
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_acc.op          <= i_op;
            r_acc.word_offset <= i_word_offset;
            r_acc.write_data  <= i_write_data;
            r_acc.pin_inputs  <= i_pin_inputs;
        end
    end

    gpr_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_acc    (r_acc),
        .o_result (stage_result)
    );

    gpr_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (stage_result),
        .o_can_take (out_can_take),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_result)
    );

    assign o_read_data    = out_result.read_data;
    assign o_drive_level  = out_result.drive_level;
    assign o_drive_enable = out_result.drive_enable;
    assign o_pull_up_on   = out_result.pull_up_on;
    assign o_pull_down_on = out_result.pull_down_on;

endmodule

>>> tb/gpio_result_checker.sv
// ----------------------------------------------------------------------------
// gpio_result_checker: result predictor and scoreboard for the GPIO bank
// Watches the access and result channels, keeps its own copy of the pin
// modes, output latch and pull state, and compares every result item field
// by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module gpio_result_checker import gpr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc_valid,
    input  logic                i_acc_ready,
    input  logic                i_op,
    input  logic [OFFSET_W-1:0] i_word_offset,
    input  logic [DATA_W-1:0]   i_write_data,
    input  logic [DATA_W-1:0]   i_pin_inputs,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  logic [DATA_W-1:0]   i_read_data,
    input  logic [DATA_W-1:0]   i_drive_level,
    input  logic [DATA_W-1:0]   i_drive_enable,
    input  logic [DATA_W-1:0]   i_pull_up_on,
    input  logic [DATA_W-1:0]   i_pull_down_on,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 40;

    // Shadow copy of the bank state
    t_fn               fn_mode  [PIN_COUNT];
    t_pull             pin_pull [PIN_COUNT];
    logic [DATA_W-1:0] out_latch;
    logic [DATA_W-1:0] pull_clk;
    t_pull             pull_mode;

    t_result expected_results [$];
    int      fail_count = 0;
    int      pending    = 0;
    int      checked    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;

    task automatic report_mismatch(string msg);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t ns] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] got,
                               logic [DATA_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s = %h, want %h",
                                      checked, name, got, want));
    endtask

    // Apply one access to the shadow state and return the result it gives
    function automatic t_result apply_access(t_access acc);
        t_result           res;
        logic [DATA_W-1:0] outs;
        int                pin;
        res = '0;
        if (acc.op == OP_WRITE) begin
            if (acc.word_offset <= OFF_FSEL_LAST) begin
                for (int k = 0; k < PINS_PER_WORD; k++) begin
                    pin = int'(acc.word_offset) * PINS_PER_WORD + k;
                    if (pin < PIN_COUNT)
                        fn_mode[pin] = acc.write_data[3*k +: 3];
                end
            end else if (acc.word_offset == OFF_SET) begin
                out_latch = (out_latch | acc.write_data) & PIN_MASK;
            end else if (acc.word_offset == OFF_CLR) begin
                out_latch = out_latch & ~acc.write_data & PIN_MASK;
            end else if (acc.word_offset == OFF_PUD) begin
                pull_mode = acc.write_data[1:0];
            end else if (acc.word_offset == OFF_PUDCLK) begin
                pull_clk = acc.write_data & PIN_MASK;
                if (pull_mode != PULL_KEEP) begin
                    for (int p = 0; p < PIN_COUNT; p++)
                        if (pull_clk[p])
                            pin_pull[p] = pull_mode;
                end
            end
        end else begin
            if (acc.word_offset <= OFF_FSEL_LAST) begin
                for (int k = 0; k < PINS_PER_WORD; k++) begin
                    pin = int'(acc.word_offset) * PINS_PER_WORD + k;
                    if (pin < PIN_COUNT)
                        res.read_data[3*k +: 3] = fn_mode[pin];
                end
            end else if (acc.word_offset == OFF_LEV) begin
                outs = '0;
                for (int p = 0; p < PIN_COUNT; p++)
                    outs[p] = (fn_mode[p] == FN_OUTPUT);
                res.read_data = ((out_latch & outs) | (acc.pin_inputs & ~outs))
                                & PIN_MASK;
            end else if (acc.word_offset == OFF_PUD) begin
                res.read_data = DATA_W'(pull_mode);
            end else if (acc.word_offset == OFF_PUDCLK) begin
                res.read_data = pull_clk;
            end
        end
        // Drive and pull vectors as they stand after the access
        res.drive_level = out_latch & PIN_MASK;
        for (int p = 0; p < PIN_COUNT; p++) begin
            res.drive_enable[p] = (fn_mode[p] == FN_OUTPUT);
            res.pull_up_on[p]   = (pin_pull[p] == PULL_UP);
            res.pull_down_on[p] = (pin_pull[p] == PULL_DOWN);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_access acc;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int p = 0; p < PIN_COUNT; p++) begin
                fn_mode[p]  = '0;
                pin_pull[p] = '0;
            end
            out_latch = '0;
            pull_clk  = '0;
            pull_mode = '0;
            expected_results.delete();
        end else begin
            // Compare first, so a result can never match the access taken
            // at the same edge
            if (i_res_valid && i_res_ready) begin
                got = '{read_data:    i_read_data,
                        drive_level:  i_drive_level,
                        drive_enable: i_drive_enable,
                        pull_up_on:   i_pull_up_on,
                        pull_down_on: i_pull_down_on};
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no access outstanding",
                                              checked));
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_data",    got.read_data,    want.read_data);
                    check_field("drive_level",  got.drive_level,  want.drive_level);
                    check_field("drive_enable", got.drive_enable, want.drive_enable);
                    check_field("pull_up_on",   got.pull_up_on,   want.pull_up_on);
                    check_field("pull_down_on", got.pull_down_on, want.pull_down_on);
                end
                checked++;
            end
            if (i_acc_valid && i_acc_ready) begin
                acc = '{op:          i_op,
                        word_offset: i_word_offset,
                        write_data:  i_write_data,
                        pin_inputs:  i_pin_inputs};
                expected_results.push_back(apply_access(acc));
            end
        end
        pending = expected_results.size();
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the GPIO register block
// Drives directed and random bus accesses through the access channel under
// several idling patterns, stalls the result channel, and takes the verdict
// from the failure count of the result checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gpr_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 3;
    localparam int PHASE_ITEMS  = 320;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 100_000;

    // Every 3-bit function field set to output, for the ten pins of a word
    localparam logic [DATA_W-1:0]   ALL_OUT        = 32'h0924_9249;
    localparam logic [OFFSET_W-1:0] OFF_TOP        = '1;
    localparam logic [OFFSET_W-1:0] OFF_AFTER_FSEL = OFF_FSEL_LAST + 10'd1;

    // Every input starts at a known value
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                acc_valid = 1'b0;
    logic                acc_op    = OP_READ;
    logic [OFFSET_W-1:0] acc_offset = '0;
    logic [DATA_W-1:0]   acc_wdata  = '0;
    logic [DATA_W-1:0]   acc_pins   = '0;
    logic                res_ready = 1'b0;
    logic                acc_ready;
    logic                res_valid;
    logic [DATA_W-1:0]   res_read_data;
    logic [DATA_W-1:0]   res_drive_level;
    logic [DATA_W-1:0]   res_drive_enable;
    logic [DATA_W-1:0]   res_pull_up_on;
    logic [DATA_W-1:0]   res_pull_down_on;

    int fail_count;
    int pending;
    int checked;

    // Idling percentages: the sender's is private to the stimulus process,
    // the receiver's is handed over with a nonblocking write
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    // Toggled by the stimulus to ask the receiver for one long hold-off
    logic hold_req = 1'b0;

    int items_sent = 0;
    int reads_sent = 0;
    int writes_sent = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    gpio_register_block u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (acc_valid),
        .o_ready        (acc_ready),
        .i_op           (acc_op),
        .i_word_offset  (acc_offset),
        .i_write_data   (acc_wdata),
        .i_pin_inputs   (acc_pins),
        .o_valid        (res_valid),
        .i_ready        (res_ready),
        .o_read_data    (res_read_data),
        .o_drive_level  (res_drive_level),
        .o_drive_enable (res_drive_enable),
        .o_pull_up_on   (res_pull_up_on),
        .o_pull_down_on (res_pull_down_on)
    );

    gpio_result_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_acc_valid    (acc_valid),
        .i_acc_ready    (acc_ready),
        .i_op           (acc_op),
        .i_word_offset  (acc_offset),
        .i_write_data   (acc_wdata),
        .i_pin_inputs   (acc_pins),
        .i_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .i_read_data    (res_read_data),
        .i_drive_level  (res_drive_level),
        .i_drive_enable (res_drive_enable),
        .i_pull_up_on   (res_pull_up_on),
        .i_pull_down_on (res_pull_down_on),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // Offer one access, idling first at the sender's current rate, and hold
    // it until the block takes it. Valid is left high on return so that a
    // following item goes out back to back.
    task automatic send_access(logic op, logic [OFFSET_W-1:0] word,
                               logic [DATA_W-1:0] data, logic [DATA_W-1:0] pins);
        while ($urandom_range(99) < tx_idle_pct) begin
            acc_valid <= 1'b0;
            @(posedge clk);
        end
        acc_valid  <= 1'b1;
        acc_op     <= op;
        acc_offset <= word;
        acc_wdata  <= data;
        acc_pins   <= pins;
        @(posedge clk);
        while (!acc_ready)
            @(posedge clk);
        items_sent++;
        if (op == OP_WRITE)
            writes_sent++;
        else
            reads_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    // Sample on the falling edge so the checker has finished with the
    // rising one.
    task automatic wait_for_drain();
        acc_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Mostly mapped words, now and then anywhere in the 1K word space
    function automatic logic [OFFSET_W-1:0] random_offset();
        case ($urandom_range(9))
            0, 1, 2, 3: return OFF_FSEL_FIRST + OFFSET_W'($urandom_range(FSEL_WORDS - 1));
            4:          return OFF_SET;
            5:          return OFF_CLR;
            6:          return OFF_LEV;
            7:          return OFF_PUD;
            8:          return OFF_PUDCLK;
            default:    return OFFSET_W'($urandom_range(1023));
        endcase
    endfunction

    // Bias towards the extremes and towards output functions, which are
    // otherwise only one field value in eight
    function automatic logic [DATA_W-1:0] random_data();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return ALL_OUT ^ ($urandom & $urandom & $urandom);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_item();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            // Pull update: store a mode, strobe the clock, read it back
            send_access(OP_WRITE, OFF_PUD, $urandom, $urandom);
            send_access(OP_WRITE, OFF_PUDCLK, random_data(), $urandom);
            send_access(OP_READ, OFF_PUDCLK, $urandom, $urandom);
        end else if (pick < 35) begin
            // Output set-up: pick functions, move the latch, read the levels
            send_access(OP_WRITE, OFF_FSEL_FIRST + OFFSET_W'($urandom_range(FSEL_WORDS - 1)),
                        random_data(), $urandom);
            send_access(OP_WRITE, $urandom_range(1) ? OFF_SET : OFF_CLR,
                        $urandom, $urandom);
            send_access(OP_READ, OFF_LEV, $urandom, $urandom);
        end else begin
            send_access($urandom_range(1) ? OP_WRITE : OP_READ, random_offset(),
                        random_data(), $urandom);
        end
    endtask

    // Result side: stall at the current rate, or hold off for a long
    // stretch when asked, counting the cycles here
    initial begin
        logic hold_ack;
        hold_ack = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            res_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Guard against a hung channel
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout: %0d results still outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int target;
        bool_hold: begin end
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, no idling on either side
        // Reset state of the level word, then function words at their limits:
        // bits 31..30 and the missing pins of the last word must not stick
        send_access(OP_READ,  OFF_LEV,        $urandom,       32'hFFFF_FFFF);
        send_access(OP_WRITE, OFF_FSEL_FIRST, 32'hFFFF_FFFF,  $urandom);
        send_access(OP_READ,  OFF_FSEL_FIRST, $urandom,       $urandom);
        send_access(OP_WRITE, OFF_FSEL_LAST,  32'hFFFF_FFFF,  $urandom);
        send_access(OP_READ,  OFF_FSEL_LAST,  $urandom,       $urandom);
        // Every pin an output
        for (int w = 0; w < FSEL_WORDS; w++)
            send_access(OP_WRITE, OFF_FSEL_FIRST + OFFSET_W'(w), ALL_OUT, $urandom);
        // Set and clear act on ones only and read as zero
        send_access(OP_WRITE, OFF_SET, 32'hFFFF_FFFF, $urandom);
        send_access(OP_READ,  OFF_SET, $urandom,      $urandom);
        send_access(OP_WRITE, OFF_CLR, 32'hAAAA_AAAA, $urandom);
        send_access(OP_READ,  OFF_CLR, $urandom,      $urandom);
        // Levels: output pins show the latch, input pins the outside
        send_access(OP_READ,  OFF_LEV, $urandom, 32'hFFFF_FFFF);
        send_access(OP_WRITE, OFF_FSEL_FIRST + 10'd2, '0, $urandom);
        send_access(OP_READ,  OFF_LEV, $urandom, '0);
        send_access(OP_WRITE, OFF_LEV, 32'hFFFF_FFFF, $urandom);
        // Pull up, pull down, keep, each through the pull clock
        send_access(OP_WRITE, OFF_PUD,    32'hFFFF_FFFE, $urandom);
        send_access(OP_READ,  OFF_PUD,    $urandom,      $urandom);
        send_access(OP_WRITE, OFF_PUDCLK, 32'hFFFF_FFFF, $urandom);
        send_access(OP_WRITE, OFF_PUD,    32'h0000_0001, $urandom);
        send_access(OP_WRITE, OFF_PUDCLK, 32'h0000_FFFF, $urandom);
        send_access(OP_WRITE, OFF_PUD,    32'h0000_0003, $urandom);
        send_access(OP_WRITE, OFF_PUDCLK, 32'hFFFF_0000, $urandom);
        send_access(OP_READ,  OFF_PUDCLK, $urandom,      $urandom);
        // Unmapped words: top of the space and just past the function words
        send_access(OP_WRITE, OFF_TOP,        32'hFFFF_FFFF, $urandom);
        send_access(OP_READ,  OFF_TOP,        $urandom,      $urandom);
        send_access(OP_READ,  OFF_AFTER_FSEL, $urandom,      $urandom);
        wait_for_drain();

        // Random part in four idling phases, draining between them
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct = 55;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 55;
                end
                default: begin
                    tx_idle_pct = 19;
                    rx_stall_pct <= 19;
                end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                // Halfway through the idle-free phase, hold the result side
                // off while the sender keeps offering, so the block backs up
                if (ph == 0 && hold_req == 1'b0 && items_sent >= target - PHASE_ITEMS / 2)
                    hold_req <= 1'b1;
                send_random_item();
            end
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
        $display("Covered %0d accesses (%0d reads, %0d writes), %0d results checked, %s",
                 items_sent, reads_sent, writes_sent, checked,
                 "over four idling patterns with a long result hold-off");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
